// ----- sv/mrc_pkg.sv -----
// Package for the Modbus RTU request checker: payload structs, status codes,
// function codes, frame limits and the byte-wide CRC-16 update.
// No dependencies.
`default_nettype none

package mrc_pkg;

    localparam int          MAX_FRAME     = 256;
    localparam int          HDR_BYTES     = 7;
    localparam int          LEN_W         = 9;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  BCAST_ADDR    = 8'h00;
    localparam logic [7:0]  DEV_ADDR_RST  = 8'h01;
    localparam logic [LEN_W-1:0] MIN_LEN     = LEN_W'(8);
    localparam logic [LEN_W-1:0] MIN_LEN_MW  = LEN_W'(9);
    localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MAX_FRAME);

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CRC  = 3'd1;
    localparam logic [2:0] ST_NOT_ADDR = 3'd2;
    localparam logic [2:0] ST_BAD_FUNC = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;
    localparam logic [2:0] ST_LONG     = 3'd5;

    // function codes
    localparam logic [7:0] FC_RD_COILS   = 8'd1;
    localparam logic [7:0] FC_RD_DISC    = 8'd2;
    localparam logic [7:0] FC_RD_HOLD    = 8'd3;
    localparam logic [7:0] FC_RD_INPUT   = 8'd4;
    localparam logic [7:0] FC_WR_COIL    = 8'd5;
    localparam logic [7:0] FC_WR_REG     = 8'd6;
    localparam logic [7:0] FC_WR_COILS   = 8'd15;
    localparam logic [7:0] FC_WR_REGS    = 8'd16;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       frame_address;
        logic [7:0]       function_code;
        logic [15:0]      start_address;
        logic [15:0]      quantity;
        logic [7:0]       data_byte_count;
        logic [15:0]      single_value;
        logic             broadcast;
        logic [LEN_W-1:0] frame_length;
    } t_out_item;

    // frame state as it stands after the current byte
    typedef struct packed {
        logic [15:0]                crc;
        logic [15:0]                rx_crc;
        logic [HDR_BYTES-1:0][7:0]  hdr;
        logic [LEN_W-1:0]           len;
        logic                       overflow;
    } t_frame_snap;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mrc_frame_acc.sv -----
// Per-frame accumulator: CRC, byte count, two-byte CRC holdback and header bytes.
// Depends on mrc_pkg.
`default_nettype none

module mrc_frame_acc
    import mrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_in_item    i_item,
    output t_frame_snap      o_snap
);

    logic [15:0]               r_crc;
    logic [LEN_W-1:0]          r_cnt;
    logic [1:0][7:0]           r_dly;
    logic [HDR_BYTES-1:0][7:0] r_hdr;
    logic                      r_ovf;

    logic [15:0]               n_crc;
    logic [LEN_W-1:0]          n_cnt;
    logic [HDR_BYTES-1:0][7:0] n_hdr;
    logic                      n_ovf;

    always_comb begin
        // the last two bytes of a frame are the CRC, so the CRC runs two bytes behind
        n_crc = (r_cnt >= LEN_W'(2)) ? crc16_byte(r_crc, r_dly[0]) : r_crc;
        n_hdr = r_hdr;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (r_cnt == LEN_W'(i)) begin
                n_hdr[i] = i_item.rx_byte;
            end
        end
        if (r_cnt >= MAX_LEN) begin
            n_cnt = r_cnt;
            n_ovf = 1'b1;
        end else begin
            n_cnt = r_cnt + LEN_W'(1);
            n_ovf = r_ovf;
        end
    end

    assign o_snap.crc      = n_crc;
    assign o_snap.rx_crc   = {i_item.rx_byte, r_dly[1]};
    assign o_snap.hdr      = n_hdr;
    assign o_snap.len      = n_cnt;
    assign o_snap.overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_item.last_byte)) begin
            r_crc <= CRC_INIT;
            r_cnt <= '0;
            r_dly <= '0;
            r_hdr <= '0;
            r_ovf <= 1'b0;
        end else if (i_en) begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
            r_dly <= {i_item.rx_byte, r_dly[1]};
            r_hdr <= n_hdr;
            r_ovf <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mrc_decode.sv -----
// Status and header field decode for a completed frame.
// Depends on mrc_pkg.
`default_nettype none

module mrc_decode
    import mrc_pkg::*;
(
    input  t_frame_snap      i_snap,
    input  wire logic [7:0]  i_dev_addr,
    output t_out_item        o_res
);

    logic [7:0]  addr;
    logic [7:0]  fc;
    logic [15:0] w45;
    logic        fc_ok;
    logic        fc_single;
    logic        fc_multi;

    always_comb begin
        addr      = i_snap.hdr[0];
        fc        = i_snap.hdr[1];
        w45       = {i_snap.hdr[4], i_snap.hdr[5]};
        fc_ok     = fc inside {FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT,
                               FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};
        fc_single = fc inside {FC_WR_COIL, FC_WR_REG};
        fc_multi  = fc inside {FC_WR_COILS, FC_WR_REGS};

        if (i_snap.overflow) begin
            o_res.status = ST_LONG;
        end else if (i_snap.len < MIN_LEN || (fc_multi && i_snap.len < MIN_LEN_MW)) begin
            o_res.status = ST_SHORT;
        end else if (i_snap.rx_crc != i_snap.crc) begin
            o_res.status = ST_BAD_CRC;
        end else if (addr != i_dev_addr && addr != BCAST_ADDR) begin
            o_res.status = ST_NOT_ADDR;
        end else if (!fc_ok) begin
            o_res.status = ST_BAD_FUNC;
        end else begin
            o_res.status = ST_OK;
        end

        o_res.frame_address   = addr;
        o_res.function_code   = fc;
        o_res.start_address   = {i_snap.hdr[2], i_snap.hdr[3]};
        o_res.quantity        = fc_single ? 16'd1 : w45;
        o_res.data_byte_count = fc_multi ? i_snap.hdr[6] : 8'h00;
        o_res.single_value    = fc_single ? w45 : 16'h0000;
        o_res.broadcast       = (addr == BCAST_ADDR);
        o_res.frame_length    = i_snap.len;
    end

endmodule

`default_nettype wire

// ----- sv/modbus_rtu_request_checker.sv -----
// Modbus RTU request checker, one frame byte per transaction, one result per frame.
// Top level; depends on mrc_pkg, mrc_frame_acc and mrc_decode.
//
// Accepts one byte per clock unless a last byte waits on a stalled output. Each
// byte is registered, then folded into the CRC-16 (init 0xFFFF, reflected poly
// 0xA001) and header capture in one pass; the byte marked last then produces a
// status/header result in the output register. Bytes that are not last keep
// flowing while a result waits on a stalled output; only a last byte waits for the
// output register to free up. Frames longer than 256 bytes report too long. The own
// address register resets to 1 and should be written only while no frame is
// in flight; the write port is always ready.
`default_nettype none

module modbus_rtu_request_checker
    import mrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [7:0]  r_dev_addr;

    logic        out_free;
    logic        proc;
    t_frame_snap snap;
    t_out_item   res;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign proc        = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    mrc_frame_acc u_acc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (proc),
        .i_item (r_in),
        .o_snap (snap)
    );

    mrc_decode u_dec (
        .i_snap    (snap),
        .i_dev_addr(r_dev_addr),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dev_addr  <= DEV_ADDR_RST;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            if (proc && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_dev_addr <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (proc && r_in.last_byte) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

// ----- sim/modbus_rtu_request_checker_test.sv -----
// Testbench for modbus_rtu_request_checker: drives request frames byte by byte and
// checks every status/header report against a cycle-free prediction of the checker.
// Depends on mrc_pkg and the modbus_rtu_request_checker RTL.
`timescale 1ns / 100ps

module modbus_rtu_request_checker_test;
    import mrc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 12;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in_data = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       o_cfg_ready;

    // predicted checker state
    logic [7:0]  model_dev_addr = DEV_ADDR_RST;
    logic [15:0] acc_crc = CRC_INIT;
    int          acc_count = 0;
    logic [7:0]  acc_delay [2];
    logic [7:0]  acc_hdr [HDR_BYTES];
    logic        acc_over = 1'b0;

    t_out_item   expected_reports [$];
    logic [7:0]  frame_buf [$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        rx_hold = 1'b0;
    int          cycle_count = 0;

    modbus_rtu_request_checker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // bit-serial form of the reflected CRC-16 update
    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        logic        fb;
        x = c;
        for (int i = 0; i < 8; i++) begin
            fb = x[0] ^ d[i];
            x = {1'b0, x[15:1]};
            if (fb) x = x ^ CRC_POLY;
        end
        return x;
    endfunction

    function automatic logic is_supported(input logic [7:0] fc);
        case (fc)
            FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT,
            FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_multi_write(input logic [7:0] fc);
        return fc == FC_WR_COILS || fc == FC_WR_REGS;
    endfunction

    function automatic logic [7:0] supported_fc(input int idx);
        case (idx)
            0: return FC_RD_COILS;
            1: return FC_RD_DISC;
            2: return FC_RD_HOLD;
            3: return FC_RD_INPUT;
            4: return FC_WR_COIL;
            5: return FC_WR_REG;
            6: return FC_WR_COILS;
            default: return FC_WR_REGS;
        endcase
    endfunction

    // bytes after the function code: a well-formed length for supported codes, a random one otherwise
    function automatic int body_len_for(input logic [7:0] fc);
        if (is_multi_write(fc)) return 5 + $urandom_range(8);
        if (is_supported(fc)) return 4;
        return $urandom_range(8, 2);
    endfunction

    task automatic clear_frame_state();
        acc_crc = CRC_INIT;
        acc_count = 0;
        acc_over = 1'b0;
        acc_delay[0] = 8'h00;
        acc_delay[1] = 8'h00;
        for (int i = 0; i < HDR_BYTES; i++) acc_hdr[i] = 8'h00;
    endtask

    // advances the frame state by one accepted byte; the last byte queues a report
    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        t_out_item   rep;
        logic [15:0] rx_crc;
        logic [15:0] w45;
        logic [7:0]  fc;
        logic [7:0]  addr;
        logic [8:0]  len;
        if (acc_count >= 2) acc_crc = crc_fold(acc_crc, acc_delay[0]);
        acc_delay[0] = acc_delay[1];
        acc_delay[1] = b;
        if (acc_count < HDR_BYTES) acc_hdr[acc_count] = b;
        if (acc_count >= MAX_FRAME) acc_over = 1'b1;
        else acc_count++;
        if (last) begin
            len = 9'(acc_count);
            addr = acc_hdr[0];
            fc = acc_hdr[1];
            rx_crc = {acc_delay[1], acc_delay[0]};
            w45 = {acc_hdr[4], acc_hdr[5]};
            if (acc_over)
                rep.status = ST_LONG;
            else if (len < MIN_LEN || (is_multi_write(fc) && len < MIN_LEN_MW))
                rep.status = ST_SHORT;
            else if (rx_crc != acc_crc)
                rep.status = ST_BAD_CRC;
            else if (addr != model_dev_addr && addr != BCAST_ADDR)
                rep.status = ST_NOT_ADDR;
            else if (!is_supported(fc))
                rep.status = ST_BAD_FUNC;
            else
                rep.status = ST_OK;
            rep.frame_address = addr;
            rep.function_code = fc;
            rep.start_address = {acc_hdr[2], acc_hdr[3]};
            rep.quantity = (fc == FC_WR_COIL || fc == FC_WR_REG) ? 16'h0001 : w45;
            rep.data_byte_count = is_multi_write(fc) ? acc_hdr[6] : 8'h00;
            rep.single_value = (fc == FC_WR_COIL || fc == FC_WR_REG) ? w45 : 16'h0000;
            rep.broadcast = (addr == BCAST_ADDR);
            rep.frame_length = len;
            expected_reports.push_back(rep);
            clear_frame_state();
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        if (expected_reports.size() == 0) begin
            $error("report with no frame pending: status %0d", got.status);
            fail_count++;
        end else begin
            want = expected_reports.pop_front();
            cmp_field("status", 16'(want.status), 16'(got.status));
            cmp_field("frame_address", 16'(want.frame_address), 16'(got.frame_address));
            cmp_field("function_code", 16'(want.function_code), 16'(got.function_code));
            cmp_field("start_address", want.start_address, got.start_address);
            cmp_field("quantity", want.quantity, got.quantity);
            cmp_field("data_byte_count", 16'(want.data_byte_count),
                      16'(got.data_byte_count));
            cmp_field("single_value", want.single_value, got.single_value);
            cmp_field("broadcast", 16'(want.broadcast), 16'(got.broadcast));
            cmp_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
        end
    endtask

    // result side: check each transaction, then pick next cycle's stall
    always @(posedge i_clk) begin : receiver
        if (i_rst_n && o_out_valid && !i_out_stall) check_report(o_out_data);
        if (rx_hold) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item item;
        item.rx_byte = b;
        item.last_byte = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_frame_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic build_body(input logic [7:0] addr, input logic [7:0] fc, input int n);
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fc);
        repeat (n) frame_buf.push_back(8'($urandom_range(255)));
        if (is_multi_write(fc) && n >= 5) frame_buf[6] = 8'(n - 5);
    endtask

    task automatic seal_frame();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[i]) c = crc_fold(c, frame_buf[i]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic send_request(input logic [7:0] addr, input logic [7:0] fc);
        build_body(addr, fc, body_len_for(fc));
        seal_frame();
        send_frame();
    endtask

    // stop offering bytes until every report is in, then let the design drain
    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own_address(input logic [7:0] a);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= a;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_dev_addr = a;
    endtask

    task automatic random_frame();
        int         kind;
        int         sel;
        int         n;
        int         idx;
        logic [7:0] addr;
        logic [7:0] fc;
        kind = $urandom_range(99);
        sel = $urandom_range(9);
        if (sel < 6) addr = model_dev_addr;
        else if (sel < 8) addr = BCAST_ADDR;
        else addr = 8'($urandom_range(255));
        if ($urandom_range(9) < 8) fc = supported_fc($urandom_range(7));
        else fc = 8'($urandom_range(255));
        if (kind < 85) begin
            build_body(addr, fc, body_len_for(fc));
            seal_frame();
            // corrupted transaction: one flipped bit anywhere
            if (kind >= 72) begin
                idx = $urandom_range(frame_buf.size() - 1);
                frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(7));
            end
        end else if (kind < 93) begin
            build_body(addr, fc, body_len_for(fc));
            seal_frame();
            n = $urandom_range(frame_buf.size() - 1, 1);
            while (frame_buf.size() > n) void'(frame_buf.pop_back());
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(24, 1)) frame_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed();
        // field extremes on an addressed read
        build_body(DEV_ADDR_RST, FC_RD_HOLD, 4);
        for (int i = 2; i < 6; i++) frame_buf[i] = 8'hFF;
        seal_frame();
        send_frame();
        // broadcast single write with all-zero fields
        build_body(BCAST_ADDR, FC_WR_REG, 4);
        for (int i = 2; i < 6; i++) frame_buf[i] = 8'h00;
        seal_frame();
        send_frame();
        // one-byte frame: missing header bytes read as zero
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        // multi-write needs nine bytes
        build_body(DEV_ADDR_RST, FC_WR_REGS, 4);
        seal_frame();
        send_frame();
        wait_for_reports();
    endtask

    task automatic test_function_codes();
        for (int i = 0; i < 8; i++) send_request(model_dev_addr, supported_fc(i));
        send_request(model_dev_addr, 8'h00);
        send_request(model_dev_addr, 8'd7);
        send_request(model_dev_addr, 8'd17);
        send_request(model_dev_addr, 8'hFF);
        // bad crc
        build_body(model_dev_addr, FC_RD_INPUT, 4);
        seal_frame();
        frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h80;
        send_frame();
        // not addressed outranks unsupported function
        send_request(8'hF7, 8'hFF);
        send_request(8'hF7, FC_RD_COILS);
        wait_for_reports();
    endtask

    task automatic test_frame_lengths();
        // one byte past the limit: counter holds, too long
        build_body(model_dev_addr, FC_WR_REGS, MAX_FRAME - 3);
        seal_frame();
        send_frame();
        build_body(model_dev_addr, FC_RD_HOLD, 3);
        seal_frame();
        send_frame();
        build_body(model_dev_addr, FC_WR_COILS, 5);
        seal_frame();
        send_frame();
        build_body(model_dev_addr, FC_WR_COILS, 4);
        seal_frame();
        send_frame();
        wait_for_reports();
    endtask

    task automatic test_own_address();
        logic [7:0] addr_set [3];
        addr_set[0] = 8'd247;
        addr_set[1] = 8'd1;
        addr_set[2] = 8'($urandom_range(246, 2));
        for (int k = 0; k < 3; k++) begin
            write_own_address(addr_set[k]);
            send_request(model_dev_addr, supported_fc($urandom_range(7)));
            send_request(BCAST_ADDR, supported_fc($urandom_range(7)));
            send_request(model_dev_addr ^ 8'h80, supported_fc($urandom_range(7)));
            send_request(8'hFF, FC_RD_HOLD);
            wait_for_reports();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        fork
            hold_receiver(400);
        join_none
        repeat (4) send_request(model_dev_addr, supported_fc($urandom_range(7)));
        wait_for_reports();
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct);
        write_own_address(8'($urandom_range(247, 1)));
        send_idle_pct = s_pct;
        recv_stall_pct <= r_pct;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            random_frame();
            send_frame();
        end
        wait_for_reports();
    endtask

    initial begin
        clear_frame_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_function_codes();
        test_frame_lengths();
        test_own_address();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(66, 0);
        test_random_traffic(0, 66);
        test_random_traffic(31, 31);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- modbus_rtu_request_checker.f -----
sv/mrc_pkg.sv
sv/mrc_frame_acc.sv
sv/mrc_decode.sv
sv/modbus_rtu_request_checker.sv
sim/modbus_rtu_request_checker_test.sv
